FILE: design/rtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg: shared types, widths and arithmetic helpers
// Holds the fixed-point format, derived widths, the sequencer state type
// and the rounding and saturation functions of the reciprocal Taylor unit.
// ----------------------------------------------------------------------------
package rtc_pkg;

    // Fixed-point format of every coefficient.
    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Quotient bits of the serial divider: 2^(2F+1) / d.
    localparam int QW  = 2 * FRAC_BITS + 2;
    // Working width of the rounded quotient magnitude, with a sign bit.
    localparam int CW  = ((QW > COEF_WIDTH) ? QW : COEF_WIDTH) + 1;
    // Exact product, its rounded and scaled form, and the term accumulator.
    localparam int PRW = 2 * COEF_WIDTH;
    localparam int PW  = PRW + 1;
    localparam int AW  = PW + 2;

    localparam int MCW = $clog2(COEF_WIDTH + 1);
    localparam int DCW = $clog2(QW + 1);

    localparam logic [1:0] LAST_IDX = 2'd3;

    localparam logic signed [COEF_WIDTH-1:0] MAXPOS = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] MAXPOS_A = AW'(MAXPOS);
    localparam logic signed [AW-1:0] MINNEG_A = -MAXPOS_A - AW'(1);
    localparam logic signed [PW-1:0] ROUND_P  = PW'(1) <<< (FRAC_BITS - 1);

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [PRW-1:0]        t_prod;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TERM,
        S_TWAIT,
        S_FIN,
        S_FWAIT,
        S_DONE
    } t_state;

    // Round half up, then drop the fraction bits.
    function automatic logic signed [PW-1:0] scale_prod(input t_prod p);
        logic signed [PW-1:0] t;
        t = PW'(p) + ROUND_P;
        return t >>> FRAC_BITS;
    endfunction

    // True when the value does not fit the coefficient width.
    function automatic logic is_ovf(input logic signed [AW-1:0] x);
        return (x > MAXPOS_A) || (x < MINNEG_A);
    endfunction

    // Clamp to the coefficient width.
    function automatic t_coef sat_coef(input logic signed [AW-1:0] x);
        t_coef v;
        if (x > MAXPOS_A) begin
            v = MAXPOS;
        end else if (x < MINNEG_A) begin
            v = ~MAXPOS;
        end else begin
            v = x[COEF_WIDTH-1:0];
        end
        return v;
    endfunction

endpackage

FILE: design/rtc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_in_if / rtc_out_if: item channels of the reciprocal Taylor unit
// Valid/ready channels carrying the input coefficients and the results.
// ----------------------------------------------------------------------------
interface rtc_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] coef0;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] coef1;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] coef2;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] coef3;

    modport source (output valid, coef0, coef1, coef2, coef3, input ready);
    modport sink   (input valid, coef0, coef1, coef2, coef3, output ready);
endinterface

interface rtc_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] recip0;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] recip1;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] recip2;
    logic signed [rtc_pkg::COEF_WIDTH-1:0] recip3;
    logic [2:0]                    order_now;
    logic                          zero_divisor;
    logic                          overflowed;

    modport source (output valid, recip0, recip1, recip2, recip3, order_now,
                    zero_divisor, overflowed, input ready);
    modport sink   (input valid, recip0, recip1, recip2, recip3, order_now,
                    zero_divisor, overflowed, output ready);
endinterface

FILE: design/rtc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_div: bit-serial reciprocal
// Restoring division of 2^(2F+1) by |u0|, one quotient bit per cycle,
// then rounding, sign restore and saturation in a final step.
// ----------------------------------------------------------------------------
module rtc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  rtc_pkg::t_coef         i_divisor,
    output logic                   o_done,
    output rtc_pkg::t_coef         o_quot,
    output logic                   o_ovf
);
    import rtc_pkg::*;

    logic                  r_busy, r_fin, r_neg;
    logic [DCW-1:0]        r_cnt;
    logic [COEF_WIDTH-1:0] r_d;
    logic [COEF_WIDTH:0]   r_rem;
    logic [QW-1:0]         r_q;
    logic                  r_done, r_ovf;
    t_coef                 r_quot;

    logic [COEF_WIDTH:0]   trial;
    logic                  ge;
    logic [QW-1:0]         q_inc;
    logic signed [CW-1:0]  qmag, qval;
    logic                  sat_hit;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem[COEF_WIDTH-1:0], (r_cnt == '0)};
        ge    = (trial >= {1'b0, r_d});
    end

    // Round the quotient to nearest, restore the sign and saturate.
    always_comb begin
        q_inc = r_q + QW'(1);
        qmag  = CW'(q_inc >> 1);
        qval  = r_neg ? -qmag : qmag;
        if (r_neg) begin
            sat_hit = (qmag > (CW'(MAXPOS) + CW'(1)));
        end else begin
            sat_hit = (qmag > CW'(MAXPOS));
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCW'(1);
                if (r_cnt == DCW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_divisor[COEF_WIDTH-1];
            r_d   <= i_divisor[COEF_WIDTH-1] ? -i_divisor : i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, r_d}) : trial;
            r_q   <= {r_q[QW-2:0], ge};
        end else if (r_fin) begin
            r_ovf  <= sat_hit;
            r_quot <= sat_hit ? (r_neg ? ~MAXPOS : MAXPOS) : qval[COEF_WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

FILE: design/rtc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_mul: bit-serial signed multiplier
// Shift-add on operand magnitudes, one multiplier bit per cycle, with the
// sign applied to the exact double-width product in a final step.
// ----------------------------------------------------------------------------
module rtc_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rtc_pkg::t_coef  i_a,
    input  rtc_pkg::t_coef  i_b,
    output logic            o_done,
    output rtc_pkg::t_prod  o_prod
);
    import rtc_pkg::*;

    logic                  r_busy, r_fin, r_neg, r_done;
    logic [MCW-1:0]        r_cnt;
    logic [COEF_WIDTH-1:0] r_mcand, r_lo;
    logic [COEF_WIDTH:0]   r_hi;
    t_prod                 r_prod;

    logic [COEF_WIDTH:0]   sum;
    logic [PRW-1:0]        mag;

    // Add the multiplicand when the current multiplier bit is set.
    always_comb begin
        sum = r_hi + (r_lo[0] ? {1'b0, r_mcand} : '0);
        mag = {r_hi[COEF_WIDTH-1:0], r_lo};
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MCW'(1);
                if (r_cnt == MCW'(COEF_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg   <= i_a[COEF_WIDTH-1] ^ i_b[COEF_WIDTH-1];
            r_mcand <= i_a[COEF_WIDTH-1] ? -i_a : i_a;
            r_lo    <= i_b[COEF_WIDTH-1] ? -i_b : i_b;
            r_hi    <= '0;
        end else if (r_busy) begin
            r_hi <= {1'b0, sum[COEF_WIDTH:1]};
            r_lo <= {sum[0], r_lo[COEF_WIDTH-1:1]};
        end else if (r_fin) begin
            r_prod <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

FILE: design/reciprocal_taylor_coefficients_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_taylor_coefficients_unit: Taylor coefficients of 1/u
// Work per item: one serial reciprocal (Q16.16) and then serial multiplies;
// order n takes n(n+1)/2-1 multiplies.
// One item at a time; the output register frees the input while waiting.
// Synchronous active-low reset clears the sticky order to one and all valids.
// ----------------------------------------------------------------------------
module reciprocal_taylor_coefficients_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtc_in_if.sink    i_in,
    rtc_out_if.source o_out
);
    import rtc_pkg::*;

    t_state r_state, n_state;

    logic [1:0]       r_track, n_track;
    logic [1:0]       r_k, r_j, r_last;
    t_coef            r_u [4];
    t_coef            r_y [4];
    t_coef            r_r, r_s;
    logic signed [AW-1:0] r_acc;
    logic             r_zd, r_ovf;
    logic             r_div_go;

    logic             r_oval;
    t_coef            r_o [4];
    logic [2:0]       r_oorder;
    logic             r_ozd, r_oovf;

    logic             accept, out_free;
    logic             div_start, div_done, div_ovf;
    t_coef            div_q;
    logic             mul_start, mul_done;
    t_coef            mul_a, mul_b;
    t_prod            mul_p;
    logic signed [AW-1:0] acc_sum, fin_val;
    logic [1:0]       kj;

    rtc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_u[0]),
        .o_done    (div_done),
        .o_quot    (div_q),
        .o_ovf     (div_ovf)
    );

    rtc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_oval || o_out.ready;

    // Sticky order update from the incoming coefficients.
    always_comb begin
        n_track = r_track;
        if (i_in.coef1 != '0 && r_track < 2'd1) n_track = 2'd1;
        if (i_in.coef2 != '0 && n_track < 2'd2) n_track = 2'd2;
        if (i_in.coef3 != '0) n_track = LAST_IDX;
    end

    // Multiplier operands and result arithmetic.
    always_comb begin
        kj      = r_k - r_j;
        mul_a   = (r_state == S_FIN) ? r_r : r_u[r_j];
        mul_b   = (r_state == S_FIN) ? r_s : r_y[kj];
        acc_sum = r_acc + AW'(scale_prod(mul_p));
        fin_val = -AW'(scale_prod(mul_p));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = (i_in.coef0 == '0) ? S_DONE : S_DIV;
            S_DIV:   if (div_done) n_state = (r_last == 2'd0) ? S_DONE : S_TERM;
            S_TERM:  n_state = S_TWAIT;
            S_TWAIT: if (mul_done) n_state = (r_j == r_k) ? S_FIN : S_TERM;
            S_FIN:   n_state = S_FWAIT;
            S_FWAIT: if (mul_done) n_state = (r_k == r_last) ? S_DONE : S_TERM;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_in.ready = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        unique case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_TERM:  mul_start  = 1'b1;
            S_FIN:   mul_start  = 1'b1;
            default: ;
        endcase
        div_start = (r_state == S_DIV) && !r_div_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_track  <= 2'd0;
            r_oval   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_DIV) && !div_done;
            if (accept) r_track <= n_track;
            if (r_state == S_DONE && out_free) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (accept) begin
                r_u[0] <= i_in.coef0;
                r_u[1] <= i_in.coef1;
                r_u[2] <= i_in.coef2;
                r_u[3] <= i_in.coef3;
                r_last <= n_track;
                r_zd   <= (i_in.coef0 == '0);
                r_ovf  <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                    r_y[i] <= (i_in.coef0 == '0 && 2'(i) <= n_track) ? MAXPOS : '0;
                end
            end
            S_DIV: if (div_done) begin
                r_r    <= div_q;
                r_y[0] <= div_q;
                r_ovf  <= div_ovf;
                r_k    <= 2'd1;
                r_j    <= 2'd1;
                r_acc  <= '0;
            end
            S_TWAIT: if (mul_done) begin
                r_acc <= acc_sum;
                r_j   <= r_j + 2'd1;
                if (r_j == r_k) begin
                    r_s   <= sat_coef(acc_sum);
                    r_ovf <= r_ovf | is_ovf(acc_sum);
                end
            end
            S_FWAIT: if (mul_done) begin
                r_y[r_k] <= sat_coef(fin_val);
                r_ovf    <= r_ovf | is_ovf(fin_val);
                r_k      <= r_k + 2'd1;
                r_j      <= 2'd1;
                r_acc    <= '0;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            for (int i = 0; i < 4; i++) r_o[i] <= r_y[i];
            r_oorder <= {1'b0, r_last} + 3'd1;
            r_ozd    <= r_zd;
            r_oovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_oval;
    assign o_out.recip0       = r_o[0];
    assign o_out.recip1       = r_o[1];
    assign o_out.recip2       = r_o[2];
    assign o_out.recip3       = r_o[3];
    assign o_out.order_now    = r_oorder;
    assign o_out.zero_divisor = r_ozd;
    assign o_out.overflowed   = r_oovf;

    // A zero divisor never reports overflow.
    a_zd_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_divisor |-> !o_out.overflowed)
        else $error("zero divisor result flagged overflow");

    // The sticky order never falls.
    a_track_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_track >= $past(r_track))
        else $error("sticky order decreased");

    // At order one, the result above the order (recip1) is zero.
    a_order_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.order_now == 3'd1 |-> o_out.recip1 == '0)
        else $error("coefficient above order not zero");

    // Multiplies are only issued while working on terms.
    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> (r_state == S_TERM || r_state == S_FIN))
        else $error("multiply started outside term phase");

endmodule

FILE: dv/rtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_checker: result predictor and scoreboard for the reciprocal Taylor unit
// Watches both item channels. Every accepted input item is run through a
// bit-exact model of the fixed-point recurrence, and every accepted result
// is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rtc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rtc_in_if    i_in,
    rtc_out_if   i_out,
    output int   o_fail_count,
    output int   o_waiting
);
    import rtc_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_coef      y [4];
        logic [2:0] order;
        logic       zero_div;
        logic       ovf;
    } t_taylor;

    t_taylor     taylor_queue [$];
    logic [1:0]  order_seen;
    int          fail_count;
    int          report_count;

    assign o_fail_count = fail_count;
    assign o_waiting    = taylor_queue.size();

    // Clamp a wide value to the coefficient width, noting any clamping.
    function automatic t_coef clamp_coef(input t_wide x, inout logic ovf);
        t_wide hi_lim;
        t_wide lo_lim;
        hi_lim = MAXPOS;
        lo_lim = -hi_lim - 1;
        if (x > hi_lim) begin
            ovf = 1'b1;
            return MAXPOS;
        end
        if (x < lo_lim) begin
            ovf = 1'b1;
            return ~MAXPOS;
        end
        return x[COEF_WIDTH-1:0];
    endfunction

    // Exact product, rounded half up and scaled down by the fraction bits.
    function automatic t_wide fixed_mul(input t_wide a, input t_wide b);
        t_wide p;
        t_wide half;
        half = 1;
        half = half <<< (FRAC_BITS - 1);
        p = a * b;
        return (p + half) >>> FRAC_BITS;
    endfunction

    // 2^(2F)/u0 with the magnitude rounded to nearest, ties away from zero.
    function automatic t_coef reciprocal_of(input t_coef u0, inout logic ovf);
        t_wide      sw;
        logic [127:0] mag;
        logic [127:0] q;
        t_wide      r;
        sw  = u0;
        mag = (sw < 0) ? -sw : sw;
        q   = (128'd1 << (2 * FRAC_BITS + 1)) / mag;
        q   = (q + 128'd1) >> 1;
        r   = q;
        if (sw < 0) begin
            r = -r;
        end
        return clamp_coef(r, ovf);
    endfunction

    // Taylor coefficients of 1/u for one input item; updates the sticky order.
    function automatic t_taylor taylor_of_reciprocal(input t_coef u [4],
                                                     inout logic [1:0] track);
        t_taylor res;
        t_wide   acc;
        t_wide   uj;
        t_wide   yk;
        t_wide   rw;
        t_wide   sw;
        t_coef   r;
        t_coef   s;
        int      n;
        res.ovf      = 1'b0;
        res.zero_div = 1'b0;
        for (int k = 0; k < 4; k++) begin
            res.y[k] = '0;
        end
        for (int j = 1; j < 4; j++) begin
            if (u[j] != 0 && j > track) begin
                track = j[1:0];
            end
        end
        n = track + 1;
        res.order = n[2:0];
        if (u[0] == 0) begin
            // Division by zero: every live coefficient pins to full scale.
            res.zero_div = 1'b1;
            for (int k = 0; k < n; k++) begin
                res.y[k] = MAXPOS;
            end
        end else begin
            r = reciprocal_of(u[0], res.ovf);
            res.y[0] = r;
            rw = r;
            for (int k = 1; k < n; k++) begin
                acc = 0;
                for (int j = 1; j <= k; j++) begin
                    uj = u[j];
                    yk = res.y[k-j];
                    acc = acc + fixed_mul(uj, yk);
                end
                s  = clamp_coef(acc, res.ovf);
                sw = s;
                res.y[k] = clamp_coef(-fixed_mul(rw, sw), res.ovf);
            end
        end
        return res;
    endfunction

    // Predict on input acceptance, compare on output acceptance.
    always @(posedge i_clk) begin
        t_coef   u [4];
        t_taylor exp_res;
        t_taylor got;
        logic [1:0] track;
        if (!i_rst_n) begin
            order_seen   <= '0;
            fail_count   <= 0;
            report_count <= 0;
            taylor_queue.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                u[0] = i_in.coef0;
                u[1] = i_in.coef1;
                u[2] = i_in.coef2;
                u[3] = i_in.coef3;
                track = order_seen;
                taylor_queue.push_back(taylor_of_reciprocal(u, track));
                order_seen <= track;
            end
            if (i_out.valid && i_out.ready) begin
                got.y[0]     = i_out.recip0;
                got.y[1]     = i_out.recip1;
                got.y[2]     = i_out.recip2;
                got.y[3]     = i_out.recip3;
                got.order    = i_out.order_now;
                got.zero_div = i_out.zero_divisor;
                got.ovf      = i_out.overflowed;
                if (taylor_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (report_count < MAX_REPORTS) begin
                        $display("result with nothing expected: y0=%h order=%0d",
                                 got.y[0], got.order);
                        report_count <= report_count + 1;
                    end
                end else begin
                    exp_res = taylor_queue.pop_front();
                    if (got.y[0] !== exp_res.y[0] || got.y[1] !== exp_res.y[1] ||
                        got.y[2] !== exp_res.y[2] || got.y[3] !== exp_res.y[3] ||
                        got.order !== exp_res.order ||
                        got.zero_div !== exp_res.zero_div ||
                        got.ovf !== exp_res.ovf) begin
                        fail_count <= fail_count + 1;
                        if (report_count < MAX_REPORTS) begin
                            $display("mismatch exp y=%h %h %h %h ord=%0d zd=%b ov=%b",
                                     exp_res.y[0], exp_res.y[1], exp_res.y[2],
                                     exp_res.y[3], exp_res.order,
                                     exp_res.zero_div, exp_res.ovf);
                            $display("         got y=%h %h %h %h ord=%0d zd=%b ov=%b",
                                     got.y[0], got.y[1], got.y[2], got.y[3],
                                     got.order, got.zero_div, got.ovf);
                            report_count <= report_count + 1;
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: dv/reciprocal_taylor_coefficients_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_taylor_coefficients_unit_tb: stimulus and verdict
// Drives directed corner items and then random coefficient sets into the
// reciprocal Taylor unit, with random gaps on both channels and one long
// receiver hold-off. Checking is done by rtc_checker.
// ----------------------------------------------------------------------------
module reciprocal_taylor_coefficients_unit_tb;
    import rtc_pkg::*;

    localparam int    RANDOM_ITEMS = 2000;
    localparam int    IDLE_PCT     = 24;
    localparam int    HOLD_CYCLES  = 3000;
    localparam int    DRAIN_CYCLES = 800;
    localparam int    CYCLE_LIMIT  = 6000000;
    localparam t_coef MINNEG       = ~MAXPOS;
    localparam t_coef ONE          = t_coef'(1) <<< FRAC_BITS;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   items_sent;
    int   fail_count;
    int   waiting;
    logic hold_output;

    rtc_in_if  in_ch ();
    rtc_out_if out_ch ();

    reciprocal_taylor_coefficients_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rtc_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver: random stalls, a quiet window, and the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_output) begin
            out_ch.ready <= 1'b0;
        end else if (cycle_count > 150000 && cycle_count < 250000) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long hold-off so that the block fills up and stalls its input.
    initial begin
        hold_output = 1'b0;
        wait (items_sent >= 300);
        @(posedge i_clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item and wait for it to be taken; may idle first.
    task automatic send_item(input t_coef c0, input t_coef c1,
                             input t_coef c2, input t_coef c3, input bit quiet);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.coef0 <= c0;
        in_ch.coef1 <= c1;
        in_ch.coef2 <= c2;
        in_ch.coef3 <= c3;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Random coefficient: mostly small values so results stay in range.
    function automatic t_coef rand_coef(input int zero_pct);
        int    pick;
        t_coef v;
        pick = $urandom_range(99);
        if (pick < zero_pct) begin
            v = '0;
        end else if (pick < zero_pct + 25) begin
            v = $urandom;
        end else if (pick < zero_pct + 30) begin
            v = ($urandom_range(1)) ? MAXPOS : MINNEG;
        end else begin
            v = t_coef'($urandom_range(1 << 20, 1));
            if ($urandom_range(1)) begin
                v = -v;
            end
        end
        return v;
    endfunction

    initial begin
        bit quiet;
        cycle_count  = 0;
        items_sent   = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.coef0  = '0;
        in_ch.coef1  = '0;
        in_ch.coef2  = '0;
        in_ch.coef3  = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Order one: reciprocal alone, including zero and saturating divisors.
        send_item(ONE, '0, '0, '0, 1'b0);
        send_item('0, '0, '0, '0, 1'b0);
        send_item(MAXPOS, '0, '0, '0, 1'b0);
        send_item(MINNEG, '0, '0, '0, 1'b0);
        send_item(t_coef'(1), '0, '0, '0, 1'b0);
        send_item(-t_coef'(1), '0, '0, '0, 1'b0);
        send_item(-ONE, '0, '0, '0, 1'b0);
        send_item(t_coef'(3 << 16), '0, '0, '0, 1'b0);
        // Order rises to two, then jumps to four on the top coefficient alone.
        send_item(ONE, ONE, '0, '0, 1'b0);
        send_item(t_coef'(2 << 16), -ONE, '0, '0, 1'b0);
        send_item(ONE, '0, '0, t_coef'(5), 1'b0);
        // Order four: a lower item keeps the sticky order.
        send_item(ONE, '0, '0, '0, 1'b0);
        send_item(ONE, ONE, ONE, ONE, 1'b0);
        send_item(MAXPOS, MAXPOS, MAXPOS, MAXPOS, 1'b0);
        send_item(MINNEG, MINNEG, MINNEG, MINNEG, 1'b0);
        send_item(t_coef'(1), MAXPOS, MINNEG, MAXPOS, 1'b0);
        send_item('0, ONE, ONE, ONE, 1'b0);
        send_item('0, '0, '0, '0, 1'b0);
        send_item(-ONE, t_coef'(32'h5555_5555), t_coef'(32'hAAAA_AAAA), '1, 1'b0);
        send_item(t_coef'(32'h0000_8000), t_coef'(32'h0001_8000), -ONE, ONE, 1'b0);

        // Random coefficient sets.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 800 && i < 1100);
            send_item(rand_coef(5), rand_coef(30), rand_coef(30), rand_coef(30),
                      quiet);
        end
        in_ch.valid <= 1'b0;

        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
